@@ hdl/pkmc_pkg.sv @@
`timescale 1ns / 1ps

package pkmc_pkg;

  // Cache geometry
  localparam int CACHE_SLOTS = 4;
  localparam int SLOT_W      = $clog2(CACHE_SLOTS);
  localparam int POS_W       = 48;
  localparam int PAGE_BITS   = 12;
  localparam int KEY_W       = POS_W - PAGE_BITS;
  localparam int OFF_W       = PAGE_BITS;
  localparam int STATUS_W    = 3;

  // Operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_DROP   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_UNCACHED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FILLED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;

  typedef struct packed {
    logic             op;
    logic [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    page_key;
    logic [OFF_W-1:0]    page_offset_out;
    logic                evicted_valid;
    logic [KEY_W-1:0]    evicted_key;
  } out_item_t;

endpackage

@@ hdl/page_key_mru_cache.sv @@
`timescale 1ns / 1ps

// Fully associative page key cache with a move-to-front order. Each transaction
// passes through an input register and then a result register, and one transaction
// is accepted every cycle while the result side is not stalled, since a lookup
// compares all slots in parallel and updates the slot registers in the same cycle
// it moves into the result register. A lookup splits the position into page key
// and offset; while the cache is enabled, a hit swaps the slot to the front, and a
// miss fills the first empty slot or evicts the last one, then moves it to the front.
// A drop invalidates every slot. Any write of cfg_wdata (cache enable) clears all
// slots.

module page_key_mru_cache (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  pkmc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pkmc_pkg::out_item_t out_item
);

  logic                     cache_enable;
  logic [pkmc_pkg::KEY_W-1:0] entry_key [pkmc_pkg::CACHE_SLOTS];
  logic [pkmc_pkg::CACHE_SLOTS-1:0] entry_valid;

  logic               stage_valid;
  pkmc_pkg::in_item_t stage_item;

  logic out_free;
  logic stage_move;
  logic stage_load;

  logic [pkmc_pkg::KEY_W-1:0] key;
  logic [pkmc_pkg::OFF_W-1:0] off;
  logic                       hit_any;
  logic                       empty_any;
  logic [pkmc_pkg::SLOT_W-1:0] hit_slot;
  logic [pkmc_pkg::SLOT_W-1:0] empty_slot;
  logic [pkmc_pkg::SLOT_W-1:0] slot;
  pkmc_pkg::out_item_t        result;

  // Handshake: result register frees when empty or taken
  assign out_free   = !out_valid || !out_stall;
  assign stage_move = stage_valid && out_free;
  assign in_stall   = stage_valid && !out_free;
  assign stage_load = in_valid && !in_stall;

  // Split the position
  assign key = stage_item.position[pkmc_pkg::POS_W-1:pkmc_pkg::PAGE_BITS];
  assign off = stage_item.position[pkmc_pkg::PAGE_BITS-1:0];

  // Find the first matching slot and the first empty slot
  always_comb begin
    hit_any    = 1'b0;
    empty_any  = 1'b0;
    hit_slot   = '0;
    empty_slot = '0;
    for (int i = pkmc_pkg::CACHE_SLOTS - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_key[i] == key) begin
        hit_any  = 1'b1;
        hit_slot = pkmc_pkg::SLOT_W'(i);
      end
      if (!entry_valid[i]) begin
        empty_any  = 1'b1;
        empty_slot = pkmc_pkg::SLOT_W'(i);
      end
    end
  end

  // Pick the slot that ends up at the front
  always_comb begin
    priority if (hit_any) begin
      slot = hit_slot;
    end else if (empty_any) begin
      slot = empty_slot;
    end else begin
      slot = pkmc_pkg::SLOT_W'(pkmc_pkg::CACHE_SLOTS - 1);
    end
  end

  // Form the result
  always_comb begin
    result.status          = pkmc_pkg::ST_UNCACHED;
    result.page_key        = key;
    result.page_offset_out = off;
    result.evicted_valid   = 1'b0;
    result.evicted_key     = '0;
    priority if (stage_item.op == pkmc_pkg::OP_DROP) begin
      result.status          = pkmc_pkg::ST_DROPPED;
      result.page_key        = '0;
      result.page_offset_out = '0;
    end else if (!cache_enable) begin
      result.status = pkmc_pkg::ST_UNCACHED;
    end else if (hit_any) begin
      result.status = pkmc_pkg::ST_HIT;
    end else if (empty_any) begin
      result.status = pkmc_pkg::ST_FILLED;
    end else begin
      result.status        = pkmc_pkg::ST_EVICTED;
      result.evicted_valid = 1'b1;
      result.evicted_key   = entry_key[pkmc_pkg::CACHE_SLOTS-1];
    end
  end

  // Hold the configuration and slot control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enable <= 1'b0;
      entry_valid  <= '0;
    end else if (cfg_wen) begin
      cache_enable <= cfg_wdata;
      entry_valid  <= '0;
    end else if (stage_move) begin
      if (stage_item.op == pkmc_pkg::OP_DROP) begin
        entry_valid <= '0;
      end else if (cache_enable) begin
        entry_valid[0] <= 1'b1;
        if (slot != '0) begin
          entry_valid[slot] <= entry_valid[0];
        end
      end
    end
  end

  // Move the selected entry to the front, old front takes its place
  always_ff @(posedge clk) begin
    if (stage_move && stage_item.op == pkmc_pkg::OP_LOOKUP && cache_enable && !cfg_wen) begin
      entry_key[0] <= key;
      if (slot != '0) begin
        entry_key[slot] <= entry_key[0];
      end
    end
  end

  // Advance the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load) begin
      stage_item <= in_item;
    end
  end

  // Advance the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      out_item <= result;
    end
  end

endmodule

@@ hdl/pkmc_checker.sv @@
`timescale 1ns / 1ps

module pkmc_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input pkmc_pkg::out_item_t out_item
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // Status stays within its codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.status <= pkmc_pkg::ST_DROPPED)
    else $error("status out of range");

  // Report an eviction exactly on an evicting lookup
  a_evict_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.evicted_valid == (out_item.status == pkmc_pkg::ST_EVICTED)))
    else $error("evicted flag disagrees with status");

  // Zero the evicted key when nothing was evicted
  a_evict_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.evicted_valid |-> out_item.evicted_key == '0)
    else $error("evicted key not zero");

  // Clear all lookup fields on a drop
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == pkmc_pkg::ST_DROPPED |->
      out_item.page_key == '0 && out_item.page_offset_out == '0)
    else $error("drop result carries lookup fields");

endmodule

bind page_key_mru_cache pkmc_checker u_pkmc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
